### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the core RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/psq_pkg.sv
// ----------------------------------------------------------------------------
// Pitch scale quantiser package
// Widths, constants, stage payload types and the note-to-sample lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package psq_pkg;

  // Block configuration
  localparam int INPUT_RANGE_NOTES = 120;
  localparam int SAMPLE_BITS       = 16;

  // Derived widths
  localparam int NUM_CLASSES = 12;
  localparam int KEY_W       = 4;
  localparam int FRAC_W      = 16;
  localparam int RANGE_W     = $clog2(INPUT_RANGE_NOTES + 1);
  localparam int PROD_W      = SAMPLE_BITS + RANGE_W;
  localparam int NOTE_W      = RANGE_W + FRAC_W;
  localparam int OCT_W       = $clog2(INPUT_RANGE_NOTES / NUM_CLASSES + 1);
  localparam int POS_W       = KEY_W + FRAC_W;
  localparam int DIST_W      = POS_W;
  localparam int M_W         = RANGE_W + 3;
  localparam int OCTAVE_Q    = NUM_CLASSES << FRAC_W;
  localparam int SAMPLE_HALF = 1 << (SAMPLE_BITS - 1);
  localparam int TWO_RANGE   = 2 * INPUT_RANGE_NOTES;

  // Reciprocal of 12 for the octave split, exact for integer parts below 511
  localparam int RECIP_12    = 171;
  localparam int RECIP_SH    = 11;
  localparam int RECIP_W     = 8;

  typedef enum logic [1:0] {
    WRAP_NONE = 2'd0,
    WRAP_DOWN = 2'd1,
    WRAP_UP   = 2'd2
  } wrap_e;

  // Output of the front end: octave and position within the octave
  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw;
    logic [OCT_W-1:0]       oct;
    logic [POS_W-1:0]       pos;
  } front_t;

  // One pitch-class candidate
  typedef struct packed {
    logic [DIST_W-1:0] gap;
    logic [KEY_W-1:0]  key;
    wrap_e             wrap;
  } lane_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]       raw;
    logic                         bypass;
    logic [OCT_W-1:0]             oct;
    lane_t [NUM_CLASSES-1:0]      lanes;
  } dist_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw;
    logic                   bypass;
    logic [RANGE_W-1:0]     note;
  } note_t;

  // Note number to output sample, round half up, top entry saturated
  typedef logic [SAMPLE_BITS-1:0] lut_t [0:INPUT_RANGE_NOTES];

  function automatic lut_t build_scale_lut();
    lut_t   lut;
    longint num;
    longint val;
    for (int i = 0; i <= INPUT_RANGE_NOTES; i++) begin
      num = (longint'(i) << (SAMPLE_BITS + 1)) + longint'(INPUT_RANGE_NOTES);
      val = num / TWO_RANGE - longint'(SAMPLE_HALF);
      if (val > longint'(SAMPLE_HALF - 1)) begin
        val = longint'(SAMPLE_HALF - 1);
      end
      lut[i] = val[SAMPLE_BITS-1:0];
    end
    return lut;
  endfunction

  localparam lut_t SCALE_LUT = build_scale_lut();

endpackage

`default_nettype wire

### rtl/core/pitch_scale_quantizer_unit.sv
// ----------------------------------------------------------------------------
// Pitch scale quantiser
// Maps each signed pitch sample to the nearest pitch class enabled in the
// scale mask and returns it scaled back to a sample.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  in_valid_i / in_ready_o carries sample_i.
//   Output channel out_valid_o / out_ready_i carries quantized_sample_o.
//   Config channel cfg_valid_i / cfg_ready_o writes scale_mask_i; it is
//   always ready and must only be written while no transaction is in flight.
//   A transaction reaches out_valid_o through two front stages (note
//   scaling, octave split), one distance stage, three selection stages
//   (minimum tree, note clamp) and the output register holding the
//   note-to-sample lookup. Throughput is one transaction per cycle
//   unless the output stalls; every stage has its own valid bit, so a
//   stalled receiver fills the pipeline bubble by bubble and the input
//   side only sees in_ready_o low once all seven stages are full.
//   Reset clears every valid bit and the scale mask, so an empty mask
//   passes samples through unchanged until the first configuration write.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pitch_scale_quantizer_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [psq_pkg::NUM_CLASSES-1:0]  scale_mask_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [psq_pkg::SAMPLE_BITS-1:0]  sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [psq_pkg::SAMPLE_BITS-1:0]  quantized_sample_o
);

  logic [psq_pkg::NUM_CLASSES-1:0] mask_q;

  logic            front_valid, front_ready;
  psq_pkg::front_t front;
  logic            dist_valid, dist_ready;
  psq_pkg::dist_t  dist_data;
  logic            note_valid, note_ready;
  psq_pkg::note_t  note;

  logic                             out_en;
  logic                             out_valid_q;
  logic [psq_pkg::SAMPLE_BITS-1:0]  out_sample_d, out_sample_q;

  // Scale mask register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (cfg_valid_i) begin
      mask_q <= scale_mask_i;
    end
  end

  psq_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_valid_i),
    .ready_o  (in_ready_o),
    .sample_i (sample_i),
    .valid_o  (front_valid),
    .ready_i  (front_ready),
    .front_o  (front)
  );

  psq_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .mask_i  (mask_q),
    .valid_i (front_valid),
    .ready_o (front_ready),
    .front_i (front),
    .valid_o (dist_valid),
    .ready_i (dist_ready),
    .dist_o  (dist_data)
  );

  psq_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dist_valid),
    .ready_o (dist_ready),
    .dist_i  (dist_data),
    .valid_o (note_valid),
    .ready_i (note_ready),
    .note_o  (note)
  );

  // Output register: note to sample lookup, or raw sample with empty mask
  assign out_en     = !out_valid_q || out_ready_i;
  assign note_ready = out_en;

  assign out_sample_d = note.bypass ? note.raw : psq_pkg::SCALE_LUT[note.note];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= note_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && note_valid) begin
      out_sample_q <= out_sample_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign quantized_sample_o = out_sample_q;

  // Back-pressure reaches the input only from a stalled, full output
  `ASSERT_IMPLIES(a_stall_origin, clk_i, rst_ni, !in_ready_o,
                  out_valid_o && !out_ready_i, "input stalled without output stall")

endmodule

`default_nettype wire

### rtl/core/psq_front.sv
// ----------------------------------------------------------------------------
// Pitch scale quantiser front end
// Two stages: offset-binary scaling to notes, then split into octave and
// position within the octave.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module psq_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic [psq_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                            valid_o,
  input  logic                            ready_i,
  output psq_pkg::front_t                 front_o
);

  localparam int SB = psq_pkg::SAMPLE_BITS;

  logic                         s1_en, s2_en;
  logic                         s1_valid_q, s2_valid_q;
  logic [SB-1:0]                s1_raw_q;
  logic [psq_pkg::PROD_W-1:0]   s1_prod_d, s1_prod_q;
  psq_pkg::front_t              s2_d, s2_q;

  logic [psq_pkg::PROD_W+psq_pkg::FRAC_W-1:0]  n_full;
  logic [psq_pkg::RANGE_W-1:0]                 note_int;
  logic [psq_pkg::RANGE_W+psq_pkg::RECIP_W-1:0] oct_prod;
  logic [psq_pkg::OCT_W-1:0]                   oct;
  logic [psq_pkg::RANGE_W-1:0]                 cls;

  // Stage enables: a stage moves when empty or when its successor moves
  assign s2_en   = !s2_valid_q || ready_i;
  assign s1_en   = !s1_valid_q || s2_en;
  assign ready_o = s1_en;

  // Stage 1: offset binary times note range
  assign s1_prod_d = psq_pkg::PROD_W'({~sample_i[SB-1], sample_i[SB-2:0]})
                   * psq_pkg::PROD_W'(psq_pkg::INPUT_RANGE_NOTES);

  // Stage 2: note value, octave by reciprocal, class by subtraction
  always_comb begin
    n_full   = {s1_prod_q, psq_pkg::FRAC_W'(0)} >> SB;
    note_int = n_full[psq_pkg::NOTE_W-1:psq_pkg::FRAC_W];
    oct_prod = (psq_pkg::RANGE_W + psq_pkg::RECIP_W)'(note_int)
             * (psq_pkg::RANGE_W + psq_pkg::RECIP_W)'(psq_pkg::RECIP_12);
    oct      = oct_prod[psq_pkg::RECIP_SH +: psq_pkg::OCT_W];
    cls      = note_int - psq_pkg::RANGE_W'(oct) * psq_pkg::RANGE_W'(psq_pkg::NUM_CLASSES);
    s2_d.raw = s1_raw_q;
    s2_d.oct = oct;
    s2_d.pos = {cls[psq_pkg::KEY_W-1:0], n_full[psq_pkg::FRAC_W-1:0]};
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (s1_en && valid_i) begin
      s1_raw_q  <= sample_i;
      s1_prod_q <= s1_prod_d;
    end
    if (s2_en && s1_valid_q) begin
      s2_q <= s2_d;
    end
  end

  assign valid_o = s2_valid_q;
  assign front_o = s2_q;

  // Position within the octave always names a real pitch class
  `ASSERT_IMPLIES(a_class_in_octave, clk_i, rst_ni, s2_valid_q,
                  s2_q.pos[psq_pkg::POS_W-1:psq_pkg::FRAC_W]
                    < psq_pkg::KEY_W'(psq_pkg::NUM_CLASSES),
                  "pitch class out of octave")

endmodule

`default_nettype wire

### rtl/core/psq_dist.sv
// ----------------------------------------------------------------------------
// Pitch scale quantiser distance lanes
// One stage: twelve parallel lanes give the short-way distance to each
// enabled pitch class and the octave wrap it implies.
// ----------------------------------------------------------------------------
`default_nettype none

module psq_dist (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [psq_pkg::NUM_CLASSES-1:0]  mask_i,
  input  logic                             valid_i,
  output logic                             ready_o,
  input  psq_pkg::front_t                  front_i,
  output logic                             valid_o,
  input  logic                             ready_i,
  output psq_pkg::dist_t                   dist_o
);

  localparam int D_W = psq_pkg::POS_W + 1;

  logic           en;
  logic           valid_q;
  psq_pkg::dist_t dist_d, dist_q;

  assign en      = !valid_q || ready_i;
  assign ready_o = en;

  // Per-class distance, disabled classes carry the all-ones sentinel
  always_comb begin
    logic signed [D_W-1:0]          d;
    logic [psq_pkg::POS_W-1:0]      ad;
    logic [psq_pkg::POS_W-1:0]      comp;
    dist_d.raw    = front_i.raw;
    dist_d.bypass = (mask_i == '0);
    dist_d.oct    = front_i.oct;
    for (int k = 0; k < psq_pkg::NUM_CLASSES; k++) begin
      d    = $signed((D_W'(k) << psq_pkg::FRAC_W) - D_W'(front_i.pos));
      ad   = d[D_W-1] ? psq_pkg::POS_W'(-d) : psq_pkg::POS_W'(d);
      comp = psq_pkg::POS_W'(psq_pkg::OCTAVE_Q) - ad;
      dist_d.lanes[k].key = psq_pkg::KEY_W'(k);
      if (ad < comp) begin
        dist_d.lanes[k].gap  = ad;
        dist_d.lanes[k].wrap = psq_pkg::WRAP_NONE;
      end else begin
        dist_d.lanes[k].gap  = comp;
        dist_d.lanes[k].wrap = (!d[D_W-1] && (d != '0)) ? psq_pkg::WRAP_DOWN
                                                        : psq_pkg::WRAP_UP;
      end
      if (!mask_i[k]) begin
        dist_d.lanes[k].gap = '1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && valid_i) begin
      dist_q <= dist_d;
    end
  end

  assign valid_o = valid_q;
  assign dist_o  = dist_q;

endmodule

`default_nettype wire

### rtl/core/psq_select.sv
// ----------------------------------------------------------------------------
// Pitch scale quantiser selection
// Three stages: registered minimum tree over the twelve lanes (12 to 3,
// then 3 to 1), then note assembly with octave wrap and range clamp.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module psq_select (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  psq_pkg::dist_t dist_i,
  output logic           valid_o,
  input  logic           ready_i,
  output psq_pkg::note_t note_o
);

  localparam int SB = psq_pkg::SAMPLE_BITS;
  localparam int MW = psq_pkg::M_W;
  localparam logic signed [MW-1:0] RANGE_S = MW'(psq_pkg::INPUT_RANGE_NOTES);

  logic s4_en, s5_en, s6_en;
  logic s4_valid_q, s5_valid_q, s6_valid_q;

  logic [SB-1:0]              s4_raw_q, s5_raw_q;
  logic                       s4_bypass_q, s5_bypass_q;
  logic [psq_pkg::OCT_W-1:0]  s4_oct_q, s5_oct_q;
  psq_pkg::lane_t [2:0]       s4_lanes_d, s4_lanes_q;
  psq_pkg::lane_t             s5_win_d, s5_win_q;
  psq_pkg::note_t             s6_d, s6_q;

  psq_pkg::lane_t [5:0]       lvl1;
  logic [MW-1:0]              m_u;
  logic signed [MW-1:0]       m_s;

  // Keep the lower class unless the higher one is strictly closer
  function automatic psq_pkg::lane_t pick_lane(input psq_pkg::lane_t lo,
                                               input psq_pkg::lane_t hi);
    return (hi.gap < lo.gap) ? hi : lo;
  endfunction

  assign s6_en   = !s6_valid_q || ready_i;
  assign s5_en   = !s5_valid_q || s6_en;
  assign s4_en   = !s4_valid_q || s5_en;
  assign ready_o = s4_en;

  // Stage 4: two tree levels, 12 to 6 to 3
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      lvl1[i] = pick_lane(dist_i.lanes[2*i], dist_i.lanes[2*i+1]);
    end
    for (int j = 0; j < 3; j++) begin
      s4_lanes_d[j] = pick_lane(lvl1[2*j], lvl1[2*j+1]);
    end
  end

  // Stage 5: last two tree levels, 3 to 1
  assign s5_win_d = pick_lane(pick_lane(s4_lanes_q[0], s4_lanes_q[1]), s4_lanes_q[2]);

  // Stage 6: octave*12 + class, apply wrap, clamp to the note range
  always_comb begin
    m_u = MW'(s5_oct_q) * MW'(psq_pkg::NUM_CLASSES) + MW'(s5_win_q.key);
    case (s5_win_q.wrap)
      psq_pkg::WRAP_DOWN: m_u = m_u - MW'(psq_pkg::NUM_CLASSES);
      psq_pkg::WRAP_UP:   m_u = m_u + MW'(psq_pkg::NUM_CLASSES);
      default:            m_u = m_u;
    endcase
    m_s = $signed(m_u);
    if (m_s < 0) begin
      s6_d.note = '0;
    end else if (m_s > RANGE_S) begin
      s6_d.note = psq_pkg::RANGE_W'(psq_pkg::INPUT_RANGE_NOTES);
    end else begin
      s6_d.note = m_s[psq_pkg::RANGE_W-1:0];
    end
    s6_d.raw    = s5_raw_q;
    s6_d.bypass = s5_bypass_q;
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      if (s4_en) s4_valid_q <= valid_i;
      if (s5_en) s5_valid_q <= s4_valid_q;
      if (s6_en) s6_valid_q <= s5_valid_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (s4_en && valid_i) begin
      s4_raw_q    <= dist_i.raw;
      s4_bypass_q <= dist_i.bypass;
      s4_oct_q    <= dist_i.oct;
      s4_lanes_q  <= s4_lanes_d;
    end
    if (s5_en && s4_valid_q) begin
      s5_raw_q    <= s4_raw_q;
      s5_bypass_q <= s4_bypass_q;
      s5_oct_q    <= s4_oct_q;
      s5_win_q    <= s5_win_d;
    end
    if (s6_en && s5_valid_q) begin
      s6_q <= s6_d;
    end
  end

  assign valid_o = s6_valid_q;
  assign note_o  = s6_q;

  // With a non-empty mask the winner is an enabled class
  `ASSERT_IMPLIES(a_winner_enabled, clk_i, rst_ni, s5_valid_q && !s5_bypass_q,
                  s5_win_q.gap != '1, "disabled pitch class selected")
  // Clamped note never exceeds the note range
  `ASSERT_IMPLIES(a_note_in_range, clk_i, rst_ni, s6_valid_q,
                  s6_q.note <= psq_pkg::RANGE_W'(psq_pkg::INPUT_RANGE_NOTES),
                  "note above range")

endmodule

`default_nettype wire
